[sv/apr_pkg.sv]
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants for the aging page replacement block.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int FRAMES    = 32;
    localparam int HIST_BITS = 8;
    localparam int PAGE_W    = 31;
    localparam int ADDR_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);

    localparam logic [HIST_BITS-1:0] HIST_TOP = {1'b1, {(HIST_BITS-1){1'b0}}};

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_OFFSET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_INTERVAL = 2'd2;

    // search word handed from cell to cell
    typedef struct packed {
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [CNT_W-1:0]     used;
        logic                 free_ok;
        logic [IDX_W-1:0]     free_idx;
        logic                 best_ok;
        logic [HIST_BITS-1:0] best_hist;
        logic [IDX_W-1:0]     best_rank;
        logic [IDX_W-1:0]     best_idx;
        logic [PAGE_W-1:0]    best_page;
        logic                 best_dirty;
    } t_scan;

    // update broadcast from the controller to every cell
    typedef struct packed {
        logic              en;
        logic              load;
        logic              evict;
        logic [IDX_W-1:0]  slot;
        logic [IDX_W-1:0]  vrank;
        logic [IDX_W-1:0]  new_rank;
        logic [PAGE_W-1:0] page;
        logic              wr;
        logic              shift;
    } t_cmd;

endpackage

[sv/apr_cell.sv]
// ----------------------------------------------------------------------------
// apr_cell
// One frame: page, valid, dirty, history and load rank, plus one stage of
// the lookup / victim search word that walks along the row of cells.
// ----------------------------------------------------------------------------
module apr_cell import apr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [PAGE_W-1:0] i_page,
    input  t_scan             i_scan,
    input  t_cmd              i_cmd,
    output t_scan             o_scan
);

    logic                 r_valid;
    logic                 r_dirty;
    logic [HIST_BITS-1:0] r_hist;
    logic [IDX_W-1:0]     r_rank;
    logic [PAGE_W-1:0]    r_page;
    t_scan                r_scan;

    logic                 n_valid;
    logic                 n_dirty;
    logic [HIST_BITS-1:0] n_hist;
    logic [IDX_W-1:0]     n_rank;
    logic [PAGE_W-1:0]    n_page;
    t_scan                n_scan;

    logic                 w_me;
    logic [HIST_BITS-1:0] w_hist_base;
    logic [HIST_BITS-1:0] w_hist_set;

    // search stage
    always_comb begin
        n_scan = i_scan;
        if (r_valid) begin
            n_scan.used = i_scan.used + CNT_W'(1);
            if (!i_scan.hit && (r_page == i_page)) begin
                n_scan.hit     = 1'b1;
                n_scan.hit_idx = i_idx;
            end
            // ranks are unique among valid frames, so the key is strict
            if (!i_scan.best_ok ||
                ({r_hist, r_rank} < {i_scan.best_hist, i_scan.best_rank})) begin
                n_scan.best_ok    = 1'b1;
                n_scan.best_hist  = r_hist;
                n_scan.best_rank  = r_rank;
                n_scan.best_idx   = i_idx;
                n_scan.best_page  = r_page;
                n_scan.best_dirty = r_dirty;
            end
        end else if (!i_scan.free_ok) begin
            n_scan.free_ok  = 1'b1;
            n_scan.free_idx = i_idx;
        end
    end

    // update on broadcast
    always_comb begin
        w_me        = i_cmd.slot == i_idx;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        n_rank      = r_rank;
        n_page      = r_page;
        w_hist_base = r_hist;
        if (i_cmd.load && w_me) begin
            n_valid     = 1'b1;
            n_page      = i_cmd.page;
            n_dirty     = i_cmd.wr;
            n_rank      = i_cmd.new_rank;
            w_hist_base = '0;
        end else if (i_cmd.load && i_cmd.evict && r_valid && (r_rank > i_cmd.vrank)) begin
            n_rank = r_rank - IDX_W'(1);
        end
        if (!i_cmd.load && w_me && i_cmd.wr) begin
            n_dirty = 1'b1;
        end
        w_hist_set = w_me ? (w_hist_base | HIST_TOP) : w_hist_base;
        n_hist     = i_cmd.shift ? (w_hist_set >> 1) : w_hist_set;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_hist  <= '0;
            r_rank  <= '0;
        end else if (i_cmd.en) begin
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_hist  <= n_hist;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_page <= n_page;
        end
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

endmodule

[sv/aging_page_replacement.sv]
// ----------------------------------------------------------------------------
// aging_page_replacement
// Aging page replacement with an 8-bit reference history per frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one memory access per beat: tdata holds the byte address,
//   tuser the write flag. m_axis returns one result beat per access.
//   The cfg channel writes page offset bits, frame count and shift interval;
//   it is always ready; users write it only while the block is idle (not enforced).
// Timing:
//   The frames sit in a row of cells; a search word walks the row, one cell
//   a cycle, collecting hit, occupancy, free frame and victim in one pass.
//   An accepted beat passes through the search state and then the update
//   state, which registers the result; the next access is taken only once
//   the block is back in idle, so accesses do not overlap.
// Reset:
//   Synchronous, active low. All frames empty, histories and counters zero,
//   registers back to 12 / 32 / 8. No clearing pass is needed.
// Stall:
//   A result waits in the output register; the next access is accepted and
//   searched meanwhile, and its update holds until the output register frees.
// ----------------------------------------------------------------------------
module aging_page_replacement import apr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // access stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ADDR_W-1:0]    s_axis_tdata,   // [31:0] address
    input  logic                 s_axis_tuser,   // [0] is_write
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [95:0]          m_axis_tdata,   // [30:0] victim_page,
                                                 // [62:31] fault_count,
                                                 // [94:63] dirty_write_count, [95] zero
    output logic [2:0]           m_axis_tuser    // [0] hit, [1] replaced, [2] victim_dirty
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_cnt;
    logic [PAGE_W-1:0] r_page;
    logic              r_wr;

    logic [4:0]        r_off;
    logic [5:0]        r_fcount;
    logic [15:0]       r_interval;
    logic [15:0]       r_phase;
    logic [31:0]       r_faults;
    logic [31:0]       r_dirty_ev;

    logic              r_out_valid;
    logic              r_out_hit;
    logic              r_out_repl;
    logic              r_out_vdirty;
    logic [PAGE_W-1:0] r_out_vpage;

    t_scan             w_scan [FRAMES+1];
    t_scan             w_last;
    t_cmd              w_cmd;
    logic              w_commit;
    logic              w_evict;
    logic [CNT_W-1:0]  w_limit;
    logic [16:0]       w_phase_next;
    logic              w_shift;
    logic [4:0]        w_sh;
    logic [PAGE_W-1:0] w_in_page;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off      <= 5'd12;
            r_fcount   <= 6'd32;
            r_interval <= 16'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAGE_OFFSET:    r_off      <= i_cfg_data[4:0];
                CFG_FRAME_COUNT:    r_fcount   <= i_cfg_data[5:0];
                CFG_SHIFT_INTERVAL: r_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // page number: offset of zero acts as one
    assign w_sh      = (r_off == 5'd0) ? 5'd1 : r_off;
    assign w_in_page = PAGE_W'(s_axis_tdata >> w_sh);

    // row of frame cells
    assign w_scan[0] = '0;
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        apr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_page  (r_page),
            .i_scan  (w_scan[g]),
            .i_cmd   (w_cmd),
            .o_scan  (w_scan[g+1])
        );
    end
    assign w_last = w_scan[FRAMES];

    always_comb begin
        if (r_fcount == 6'd0) begin
            w_limit = CNT_W'(1);
        end else if (32'(r_fcount) > 32'(FRAMES)) begin
            w_limit = CNT_W'(FRAMES);
        end else begin
            w_limit = CNT_W'(r_fcount);
        end
    end

    assign w_commit     = (r_state == ST_UPDATE) && (!r_out_valid || m_axis_tready);
    assign w_evict      = !w_last.hit && (w_last.used >= w_limit);
    assign w_phase_next = {1'b0, r_phase} + 17'd1;
    assign w_shift      = w_phase_next >= {1'b0, r_interval};

    always_comb begin
        w_cmd          = '0;
        w_cmd.en       = w_commit;
        w_cmd.load     = !w_last.hit;
        w_cmd.evict    = w_evict;
        w_cmd.vrank    = w_last.best_rank;
        w_cmd.page     = r_page;
        w_cmd.wr       = r_wr;
        w_cmd.shift    = w_shift;
        w_cmd.new_rank = w_evict ? IDX_W'(w_last.used - CNT_W'(1)) : IDX_W'(w_last.used);
        if (w_last.hit) begin
            w_cmd.slot = w_last.hit_idx;
        end else if (w_evict) begin
            w_cmd.slot = w_last.best_idx;
        end else begin
            w_cmd.slot = w_last.free_idx;
        end
    end

    // control and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_phase     <= '0;
            r_faults    <= '0;
            r_dirty_ev  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_SEARCH;
                        r_cnt   <= '0;
                    end
                end
                ST_SEARCH: begin
                    r_cnt <= r_cnt + IDX_W'(1);
                    if (r_cnt == IDX_W'(FRAMES - 1)) begin
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (w_commit) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                        r_phase     <= w_shift ? 16'd0 : w_phase_next[15:0];
                        if (!w_last.hit) begin
                            r_faults <= r_faults + 32'd1;
                        end
                        if (w_evict && w_last.best_dirty) begin
                            r_dirty_ev <= r_dirty_ev + 32'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_page <= w_in_page;
            r_wr   <= s_axis_tuser;
        end
        if (w_commit) begin
            r_out_hit    <= w_last.hit;
            r_out_repl   <= w_evict;
            r_out_vdirty <= w_evict && w_last.best_dirty;
            r_out_vpage  <= w_evict ? w_last.best_page : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_dirty_ev, r_faults, r_out_vpage};
    assign m_axis_tuser  = {r_out_vdirty, r_out_repl, r_out_hit};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("access accepted while another is in flight");

    a_free_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit && !w_last.hit && !w_evict |-> w_last.free_ok)
        else $error("load without eviction found no free frame");

    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit && w_evict |-> w_last.best_ok)
        else $error("eviction without a valid victim");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("result both hit and replaced");

endmodule
